### design/bffa_pkg.sv
// shared types and codes for the first-fit slot allocator
package bffa_pkg;

  typedef logic [2:0] op_t;

  localparam op_t OP_NONE = 3'd0;
  localparam op_t OP_LOAD = 3'd1;
  localparam op_t OP_SCAN = 3'd2;
  localparam op_t OP_MARK = 3'd3;
  localparam op_t OP_FREE = 3'd4;
  localparam op_t OP_OUT  = 3'd5;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam int unsigned COUNT_MAX = 63;

  typedef struct packed {
    op_t  op;
    logic grant;
  } bffa_cmd_t;

  typedef struct packed {
    logic is_free_op;
    logic len_zero;
    logic len_ok;
    logic scan_hit;
    logic scan_last;
    logic rem_last;
    logic out_free;
  } bffa_status_t;

endpackage

### design/bitmap_first_fit_allocator.sv
// top level of the first-fit contiguous slot allocator
// Keeps one used bit per slot (all free after reset). An allocate transaction
// (kind 0) scans the bitmap from slot 0 one slot per cycle, tracking the length
// of the current free stretch; the first time it reaches run_length the start is
// recorded and the run is marked used one slot per cycle. A run_length of zero or
// above SLOTS is refused at once. A free transaction (kind 1) clears run_length
// slots from start_slot, one slot per cycle, skipping positions past the last
// slot. Every transaction yields one result with the granted flag, the run start
// (zero unless granted) and the free-slot count after the transaction, saturated
// at 63. A new transaction is taken once the previous result is in the output
// register, even if that result has not yet been taken.
module bitmap_first_fit_allocator #(
  parameter int unsigned SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [5:0] in_run_length,
  input  logic [4:0] in_start_slot,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_slot_index,
  output logic       out_granted,
  output logic [5:0] out_free_count
);
  import bffa_pkg::*;

  // command and status between sequencer and datapath
  bffa_cmd_t    cmd;
  bffa_status_t sts;

  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bffa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_run_length  (in_run_length),
    .in_start_slot  (in_start_slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot_index (out_slot_index),
    .out_granted    (out_granted),
    .out_free_count (out_free_count)
  );

endmodule

### design/bffa_ctrl.sv
// sequencer for load, first-fit scan, run marking, run freeing and result handoff
module bffa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bffa_pkg::bffa_status_t sts,
  output bffa_pkg::bffa_cmd_t    cmd
);
  import bffa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       grant_r, grant_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    grant_nxt = grant_r;
    cmd.op    = OP_NONE;
    cmd.grant = grant_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_free_op) begin
          if (sts.len_zero) begin
            grant_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FREE;
          end
        end else if (!sts.len_ok) begin
          grant_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.scan_hit) begin
          state_nxt = S_MARK;
        end else if (sts.scan_last) begin
          grant_nxt = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_MARK: begin
        cmd.op = OP_MARK;
        if (sts.rem_last) begin
          grant_nxt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_FREE: begin
        cmd.op = OP_FREE;
        if (sts.rem_last) begin
          grant_nxt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      grant_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      grant_r <= grant_nxt;
    end
  end

endmodule

### design/bffa_datapath.sv
// slot bitmap, free counter, scan pointer and result register
module bffa_datapath #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bffa_pkg::bffa_cmd_t    cmd,
  output bffa_pkg::bffa_status_t sts,
  input  logic                   in_kind,
  input  logic [5:0]             in_run_length,
  input  logic [4:0]             in_start_slot,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [4:0]             out_slot_index,
  output logic                   out_granted,
  output logic [5:0]             out_free_count
);
  import bffa_pkg::*;

  localparam int unsigned PW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned EW = (LW > 6) ? LW : 6;
  localparam int unsigned QW = ((EW > PW) ? EW : PW) + 1;
  localparam int unsigned IW = (PW > 5) ? PW : 5;

  logic [SLOTS-1:0] map_r, map_nxt;
  logic [LW-1:0]    free_cnt_r, free_cnt_nxt;
  logic [QW-1:0]    pos_r, pos_nxt;
  logic [EW-1:0]    run_r, run_nxt;
  logic [EW-1:0]    len_r, len_nxt;
  logic [EW-1:0]    rem_r, rem_nxt;
  logic             kind_r, kind_nxt;
  logic [PW-1:0]    res_idx_r, res_idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [4:0]       out_idx_r, out_idx_nxt;
  logic             out_grant_r, out_grant_nxt;
  logic [5:0]       out_cnt_r, out_cnt_nxt;

  logic             in_range;
  logic [PW-1:0]    idx;
  logic             cur_used;
  logic [QW-1:0]    hit_start;
  logic [EW-1:0]    cnt_ext;
  logic [IW-1:0]    idx_ext;

  assign in_range  = (pos_r < QW'(SLOTS));
  assign idx       = pos_r[PW-1:0];
  assign cur_used  = in_range ? map_r[idx] : 1'b0;
  assign hit_start = pos_r - QW'(len_r) + QW'(1);
  assign cnt_ext   = EW'(free_cnt_r);
  assign idx_ext   = IW'(res_idx_r);

  assign sts.is_free_op = (kind_r == KIND_FREE);
  assign sts.len_zero   = (len_r == '0);
  assign sts.len_ok     = (len_r != '0) && (len_r <= EW'(SLOTS));
  assign sts.scan_hit   = !cur_used && ((run_r + EW'(1)) == len_r);
  assign sts.scan_last  = (pos_r == QW'(SLOTS - 1));
  assign sts.rem_last   = (rem_r == EW'(1));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    map_nxt       = map_r;
    free_cnt_nxt  = free_cnt_r;
    pos_nxt       = pos_r;
    run_nxt       = run_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    kind_nxt      = kind_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_grant_nxt = out_grant_r;
    out_cnt_nxt   = out_cnt_r;
    case (cmd.op)
      OP_LOAD: begin
        kind_nxt    = in_kind;
        len_nxt     = EW'(in_run_length);
        rem_nxt     = EW'(in_run_length);
        run_nxt     = '0;
        res_idx_nxt = '0;
        pos_nxt     = (in_kind == KIND_FREE) ? QW'(in_start_slot) : '0;
      end
      OP_SCAN: begin
        if (sts.scan_hit) begin
          pos_nxt     = hit_start;
          res_idx_nxt = hit_start[PW-1:0];
          rem_nxt     = len_r;
        end else begin
          run_nxt = cur_used ? '0 : run_r + EW'(1);
          pos_nxt = pos_r + QW'(1);
        end
      end
      OP_MARK: begin
        map_nxt[idx] = 1'b1;
        free_cnt_nxt = free_cnt_r - LW'(1);
        pos_nxt      = pos_r + QW'(1);
        rem_nxt      = rem_r - EW'(1);
      end
      OP_FREE: begin
        // positions past the last slot are skipped
        if (cur_used) begin
          map_nxt[idx] = 1'b0;
          free_cnt_nxt = free_cnt_r + LW'(1);
        end
        pos_nxt = pos_r + QW'(1);
        rem_nxt = rem_r - EW'(1);
      end
      OP_OUT: begin
        out_valid_nxt = 1'b1;
        out_grant_nxt = cmd.grant;
        out_idx_nxt   = idx_ext[4:0];
        out_cnt_nxt   = (cnt_ext > EW'(COUNT_MAX)) ? 6'(COUNT_MAX) : cnt_ext[5:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r       <= '0;
      free_cnt_r  <= LW'(SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      map_r       <= map_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    run_r       <= run_nxt;
    len_r       <= len_nxt;
    rem_r       <= rem_nxt;
    kind_r      <= kind_nxt;
    res_idx_r   <= res_idx_nxt;
    out_idx_r   <= out_idx_nxt;
    out_grant_r <= out_grant_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_slot_index = out_idx_r;
  assign out_granted    = out_grant_r;
  assign out_free_count = out_cnt_r;

endmodule

### sim/tb_top.sv
// self-checking testbench for the first-fit contiguous slot allocator
`timescale 1ns / 1ps

module tb_top;
  import bffa_pkg::*;

  localparam int unsigned SLOT_COUNT = 32;

  // one request transaction as the sender offers it
  typedef struct packed {
    logic       kind;
    logic [5:0] run_length;
    logic [4:0] start_slot;
  } slot_request_t;

  // one result transaction as the block returns it
  typedef struct packed {
    logic [4:0] slot_index;
    logic       granted;
    logic [5:0] free_count;
  } slot_grant_t;

  // receiver back-pressure styles, taken in turn
  typedef enum logic [1:0] {RX_STEADY, RX_PATTERN, RX_CHOPPY, RX_COIN} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_kind = KIND_ALLOC;
  logic [5:0] in_run_length = '0;
  logic [4:0] in_start_slot = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] out_slot_index;
  logic       out_granted;
  logic [5:0] out_free_count;

  slot_request_t request_queue[$];
  slot_grant_t   grant_queue[$];
  slot_request_t next_req;
  slot_grant_t   want;

  // shadow of the block's used bits, 1 = used
  logic [SLOT_COUNT-1:0] used_map = '0;

  int unsigned sent_count = 0;
  int unsigned burst_left = 0;
  int unsigned idle_left = 0;
  int unsigned ready_cycle = 0;
  int unsigned holdoff_left = 0;
  logic        holdoff_active = 1'b0;
  logic        holdoff_done = 1'b0;
  int unsigned error_count = 0;

  bitmap_first_fit_allocator #(
    .SLOTS(SLOT_COUNT)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_run_length (in_run_length),
    .in_start_slot (in_start_slot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_slot_index(out_slot_index),
    .out_granted   (out_granted),
    .out_free_count(out_free_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // synchronous reset, never asserted again
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // first-fit allocate or run free on the shadow map; returns what the block
  // should report for this transaction
  function automatic slot_grant_t apply_slot_request(input logic kind,
                                                     input logic [5:0] run_length,
                                                     input logic [4:0] start_slot);
    slot_grant_t res;
    int          len;
    int          first;
    int          s;
    int          i;
    int          free_n;
    bit          fits;
    res = '0;
    len = int'(run_length);
    first = int'(start_slot);
    if (kind == KIND_ALLOC) begin
      // zero length and runs longer than the map are refused outright
      if (len >= 1 && len <= int'(SLOT_COUNT)) begin
        for (s = 0; s + len <= int'(SLOT_COUNT) && !res.granted; s++) begin
          fits = 1'b1;
          for (i = 0; i < len; i++) begin
            if (used_map[s + i]) fits = 1'b0;
          end
          if (fits) begin
            for (i = 0; i < len; i++) used_map[s + i] = 1'b1;
            res.slot_index = s[4:0];
            res.granted = 1'b1;
          end
        end
      end
    end else begin
      // positions past the last slot are dropped
      for (i = 0; i < len; i++) begin
        if (first + i < int'(SLOT_COUNT)) used_map[first + i] = 1'b0;
      end
      res.granted = 1'b1;
    end
    free_n = 0;
    for (i = 0; i < int'(SLOT_COUNT); i++) begin
      if (!used_map[i]) free_n++;
    end
    if (free_n > int'(COUNT_MAX)) free_n = int'(COUNT_MAX);
    res.free_count = free_n[5:0];
    return res;
  endfunction

  task automatic add_request(input logic kind, input int len, input int start);
    slot_request_t r;
    r.kind = kind;
    r.run_length = len[5:0];
    r.start_slot = start[4:0];
    request_queue.push_back(r);
  endtask

  // driver: bursts of transactions with random gaps; gaps are skipped while
  // the receiver holds off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= $urandom_range(1, 12);
      idle_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        grant_queue.push_back(apply_slot_request(in_kind, in_run_length, in_start_slot));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (idle_left != 0 && !holdoff_active) begin
          idle_left <= idle_left - 1;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          next_req = request_queue.pop_front();
          in_valid <= 1'b1;
          in_kind <= next_req.kind;
          in_run_length <= next_req.run_length;
          in_start_slot <= next_req.start_slot;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            // a third of the bursts run back to back
            idle_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off once the run is well under way
  always @(posedge clk) begin
    if (!rst_n) begin
      holdoff_active <= 1'b0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_active) begin
      if (holdoff_left <= 1) holdoff_active <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && sent_count >= 150) begin
      holdoff_active <= 1'b1;
      holdoff_left <= 600;
      holdoff_done <= 1'b1;
    end
  end

  // receiver: its own stall pattern, cycling through the styles in turn
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_cycle <= 0;
    end else begin
      ready_cycle <= ready_cycle + 1;
      if (holdoff_active) begin
        out_ready <= 1'b0;
      end else begin
        case (rx_mode_t'(ready_cycle[9:8]))
          RX_STEADY:  out_ready <= 1'b1;
          RX_PATTERN: out_ready <= (ready_cycle % 7) > 2;
          RX_CHOPPY:  out_ready <= $urandom_range(0, 3) != 0;
          default:    out_ready <= $urandom_range(0, 1) != 0;
        endcase
      end
    end
  end

  // monitor: each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (grant_queue.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < 10)
          $display("ERROR: unexpected result index=%0d granted=%0b free=%0d",
                   out_slot_index, out_granted, out_free_count);
      end else begin
        want = grant_queue.pop_front();
        if (want.slot_index !== out_slot_index || want.granted !== out_granted ||
            want.free_count !== out_free_count) begin
          error_count <= error_count + 1;
          if (error_count < 10)
            $display({"ERROR: exp index=%0d granted=%0b free=%0d, ",
                      "got index=%0d granted=%0b free=%0d"},
                     want.slot_index, want.granted, want.free_count,
                     out_slot_index, out_granted, out_free_count);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned n;
    int unsigned alloc_pct;
    int unsigned pick;
    int          len;

    // directed: refusals, full map, past-end free, fragmentation and first fit
    add_request(KIND_ALLOC, 0, 0);     // zero-length allocate
    add_request(KIND_ALLOC, 33, 17);   // longer than the map
    add_request(KIND_ALLOC, 63, 31);   // all length bits set
    add_request(KIND_ALLOC, 32, 0);    // whole map
    add_request(KIND_ALLOC, 1, 0);     // map full
    add_request(KIND_FREE, 0, 31);     // zero-length free
    add_request(KIND_FREE, 63, 31);    // free running past the last slot
    add_request(KIND_ALLOC, 1, 5);     // lands on the top slot
    add_request(KIND_FREE, 32, 0);
    add_request(KIND_FREE, 3, 5);      // already free
    add_request(KIND_ALLOC, 3, 0);
    add_request(KIND_ALLOC, 5, 0);
    add_request(KIND_ALLOC, 2, 0);
    add_request(KIND_FREE, 5, 3);      // opens a hole at 3..7
    add_request(KIND_ALLOC, 6, 0);     // too big for the hole
    add_request(KIND_ALLOC, 4, 0);     // first fit into the hole
    add_request(KIND_ALLOC, 1, 0);
    add_request(KIND_ALLOC, 16, 0);
    add_request(KIND_ALLOC, 1, 0);     // map full again
    add_request(KIND_FREE, 16, 16);
    add_request(KIND_ALLOC, 17, 0);    // one more than is free
    add_request(KIND_ALLOC, 16, 0);
    add_request(KIND_FREE, 63, 0);

    // random: phases that lean toward filling or draining the map
    alloc_pct = 70;
    for (n = 0; n < 430; n++) begin
      if (n % 40 == 0) alloc_pct = $urandom_range(25, 90);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < alloc_pct) begin
        if (pick < 70) len = $urandom_range(1, 6);
        else if (pick < 88) len = $urandom_range(7, 16);
        else if (pick < 96) len = $urandom_range(17, 32);
        else len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63);
        add_request(KIND_ALLOC, len, $urandom_range(0, 31));
      end else begin
        if (pick < 75) len = $urandom_range(1, 8);
        else if (pick < 95) len = $urandom_range(9, 32);
        else len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63);
        add_request(KIND_FREE, len, $urandom_range(0, 31));
      end
    end

    while (rst_n !== 1'b1) @(posedge clk);
    while (request_queue.size() != 0 || in_valid) @(posedge clk);
    while (grant_queue.size() != 0) @(posedge clk);
    // room for a stray extra result to show up
    repeat (100) @(posedge clk);

    if (error_count == 0 && grant_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
